@@ hdl/lrsi_pkg.sv @@
`timescale 1ns / 1ps
package lrsi_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int STAGE_WIDTH = 48;
	localparam int PRICE_W     = 32;
	localparam int GAMMA_W     = FRAC_BITS + 1;
	localparam int RSI_W       = FRAC_BITS + 1;

	// 1.0 in Q1.FRAC_BITS
	localparam logic [GAMMA_W-1:0] ONE_FX = GAMMA_W'(1) << FRAC_BITS;
	localparam logic [GAMMA_W-1:0] GAMMA_RESET = ONE_FX >> 1;

endpackage

@@ hdl/lrsi_sample_if.sv @@
`timescale 1ns / 1ps
interface lrsi_sample_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [lrsi_pkg::PRICE_W-1:0]    close_price;
	logic                                   first_in_series;

	modport source(output valid, close_price, first_in_series, input ready);
	modport sink(input valid, close_price, first_in_series, output ready);
endinterface

@@ hdl/lrsi_result_if.sv @@
`timescale 1ns / 1ps
interface lrsi_result_if;
	logic                           valid;
	logic                           ready;
	logic [lrsi_pkg::RSI_W-1:0]     rsi;

	modport source(output valid, rsi, input ready);
	modport sink(input valid, rsi, output ready);
endinterface

@@ hdl/laguerre_rsi_filter_core.sv @@
`timescale 1ns / 1ps
// Laguerre RSI filter.
// sample channel: one close price (signed Q16.16) per word, with first_in_series
//   clearing the four filter stages and the held RSI before that price is used.
// result channel: one RSI word (Q1.16, 0..65536) for every sample word.
// gamma_we/gamma_wdata: damping factor, Q1.16; values above 1.0 act as 1.0.
//   Write it only while the block is idle.
// One shared 48x17 multiplier runs the eight filter products, each as multiply,
// round and accumulate, then four passes of stage differences, normalize steps
// that halve both sums until they fit, a restoring divider for the 17 quotient
// bits and a hand-off state. When both sums are zero the divider is skipped.
// The block takes one sample at a time.
// The result sits in an output register: the next sample is taken while it
// waits, and the sequencer only stalls at its hand-off cycle if the receiver
// still holds off the previous word.
// Reset (arst_n low): stages and held RSI are zero, gamma is 0.5, no word is
// pending on the result channel.
module laguerre_rsi_filter_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          gamma_we,
	input  logic [lrsi_pkg::GAMMA_W-1:0]  gamma_wdata,
	lrsi_sample_if.sink                   sample,
	lrsi_result_if.source                 result
);

	localparam int SW     = lrsi_pkg::STAGE_WIDTH;
	localparam int FB     = lrsi_pkg::FRAC_BITS;
	localparam int GW     = lrsi_pkg::GAMMA_W;
	localparam int RW     = lrsi_pkg::RSI_W;
	localparam int ACC_W  = SW + 2;
	localparam int PROD_W = SW + GW;
	localparam int SUM_W  = SW + 2;
	localparam int TOT_W  = SUM_W + 1;
	localparam int DIV_W  = 64;
	localparam int DCNT_W = $clog2(RW);

	localparam logic signed [SW-1:0]    SMAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0]    SMIN = {1'b1, {(SW-1){1'b0}}};
	localparam logic [PROD_W-1:0]       HALF = PROD_W'(1) << (FB - 1);
	localparam logic [DIV_W-1:0]        DIV_LIMIT = (DIV_W'(1) << (DIV_W - 1 - FB)) - DIV_W'(1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_RND,
		ST_ACC,
		ST_DIFF,
		ST_NORM,
		ST_DIV,
		ST_FIN
	} state_t;

	function automatic logic signed [SW-1:0] sat_stage(input logic signed [ACC_W-1:0] v);
		logic signed [SW-1:0] r;
		if (v > ACC_W'(SMAX))
			r = SMAX;
		else if (v < ACC_W'(SMIN))
			r = SMIN;
		else
			r = v[SW-1:0];
		return r;
	endfunction

	state_t                 state_q;
	logic [GW-1:0]          gamma_q;
	logic signed [SW-1:0]   ring_q [4];
	logic signed [SW-1:0]   price_q;
	logic signed [SW-1:0]   prev_q;
	logic signed [SW-1:0]   acc_q;
	logic signed [SW-1:0]   term_q;
	logic [PROD_W-1:0]      prod_q;
	logic                   neg_q;
	logic [2:0]             step_q;
	logic [1:0]             didx_q;
	logic [DCNT_W-1:0]      dcnt_q;
	logic [SUM_W-1:0]       up_q;
	logic [SUM_W-1:0]       dn_q;
	logic [DIV_W-1:0]       rem_q;
	logic [DIV_W-1:0]       dsr_q;
	logic [RW-1:0]          quo_q;
	logic [RW-1:0]          held_q;
	logic                   res_valid_q;
	logic [RW-1:0]          rsi_q;

	logic [GW-1:0]          g_eff;
	logic [GW-1:0]          one_minus_g;
	logic signed [SW-1:0]   mul_op;
	logic [GW-1:0]          mul_f;
	logic [SW-1:0]          mul_mag;
	logic [PROD_W-1:0]      rnd_full;
	logic [SW:0]            rnd_mag;
	logic signed [ACC_W-1:0] rnd_pos;
	logic signed [ACC_W-1:0] rnd_signed;
	logic [1:0]             k;
	logic                   odd;
	logic signed [ACC_W-1:0] sub_w;
	logic signed [ACC_W-1:0] add_w;
	logic signed [SW:0]     diff;
	logic [SW:0]            diff_mag;
	logic [TOT_W-1:0]       tot;
	logic [DIV_W-1:0]       rem_diff;
	logic                   rem_ge;
	logic [RW-1:0]          quo_next;

	assign g_eff       = (gamma_q > lrsi_pkg::ONE_FX) ? lrsi_pkg::ONE_FX : gamma_q;
	assign one_minus_g = lrsi_pkg::ONE_FX - g_eff;
	assign k           = step_q[2:1];
	assign odd         = step_q[0];

	// operand pick for the shared multiplier
	always_comb begin
		priority if (odd) begin
			mul_op = ring_q[0];
			mul_f  = g_eff;
		end else if (k == 2'd0) begin
			mul_op = price_q;
			mul_f  = one_minus_g;
		end else begin
			mul_op = ring_q[3];
			mul_f  = g_eff;
		end
	end

	assign mul_mag    = mul_op[SW-1] ? SW'(-mul_op) : SW'(mul_op);
	assign rnd_full   = (prod_q + HALF) >> FB;
	assign rnd_mag    = rnd_full[SW:0];
	assign rnd_pos    = ACC_W'($signed({1'b0, rnd_mag}));
	assign rnd_signed = neg_q ? -rnd_pos : rnd_pos;

	assign sub_w = ACC_W'(prev_q) - ACC_W'(term_q);
	assign add_w = ACC_W'(acc_q) + ACC_W'(term_q);

	assign diff     = (SW+1)'(ring_q[0]) - (SW+1)'(ring_q[1]);
	assign diff_mag = diff[SW] ? (SW+1)'(-diff) : (SW+1)'(diff);

	assign tot = TOT_W'(up_q) + TOT_W'(dn_q);

	assign rem_ge   = rem_q >= dsr_q;
	assign rem_diff = rem_q - dsr_q;
	assign quo_next = {quo_q[RW-2:0], rem_ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q <= lrsi_pkg::GAMMA_RESET;
		end else if (gamma_we) begin
			gamma_q <= gamma_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			didx_q      <= '0;
			dcnt_q      <= '0;
			held_q      <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < 4; i++) ring_q[i] <= '0;
		end else begin
			// the hand-off state drives the valid flag itself
			if (result.ready && state_q != ST_FIN)
				res_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (sample.valid) begin
						price_q <= SW'(sample.close_price);
						if (sample.first_in_series) begin
							for (int i = 0; i < 4; i++) ring_q[i] <= '0;
							held_q <= '0;
						end
						step_q  <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q  <= PROD_W'(mul_mag) * PROD_W'(mul_f);
					neg_q   <= mul_op[SW-1];
					state_q <= ST_RND;
				end
				ST_RND: begin
					term_q  <= sat_stage(rnd_signed);
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (odd) begin
						// new stage enters at the tail; keep the old head for the next stage
						prev_q    <= ring_q[0];
						ring_q[0] <= ring_q[1];
						ring_q[1] <= ring_q[2];
						ring_q[2] <= ring_q[3];
						ring_q[3] <= sat_stage(add_w);
					end else if (k == 2'd0) begin
						acc_q <= term_q;
					end else begin
						acc_q <= sat_stage(sub_w);
					end
					step_q <= step_q + 3'd1;
					if (step_q == 3'd7) begin
						up_q    <= '0;
						dn_q    <= '0;
						didx_q  <= '0;
						state_q <= ST_DIFF;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_DIFF: begin
					// fourth pass only rotates the ring back into order
					if (didx_q != 2'd3) begin
						if (!diff[SW])
							up_q <= up_q + SUM_W'(diff_mag);
						else
							dn_q <= dn_q + SUM_W'(diff_mag);
					end
					ring_q[0] <= ring_q[1];
					ring_q[1] <= ring_q[2];
					ring_q[2] <= ring_q[3];
					ring_q[3] <= ring_q[0];
					didx_q    <= didx_q + 2'd1;
					if (didx_q == 2'd3)
						state_q <= ST_NORM;
				end
				ST_NORM: begin
					priority if (tot == '0) begin
						state_q <= ST_FIN;
					end else if (DIV_W'(tot) > DIV_LIMIT) begin
						up_q <= up_q >> 1;
						dn_q <= dn_q >> 1;
					end else begin
						rem_q   <= (DIV_W'(up_q) << FB) + DIV_W'(tot >> 1);
						dsr_q   <= DIV_W'(tot) << FB;
						quo_q   <= '0;
						dcnt_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (rem_ge)
						rem_q <= rem_diff;
					dsr_q  <= dsr_q >> 1;
					quo_q  <= quo_next;
					dcnt_q <= dcnt_q + DCNT_W'(1);
					if (dcnt_q == DCNT_W'(RW - 1)) begin
						held_q  <= quo_next;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!res_valid_q || result.ready) begin
						res_valid_q <= 1'b1;
						rsi_q       <= held_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign sample.ready = (state_q == ST_IDLE);
	assign result.valid = res_valid_q;
	assign result.rsi   = rsi_q;

endmodule

@@ hdl/lrsi_checker.sv @@
`timescale 1ns / 1ps
module lrsi_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [lrsi_pkg::RSI_W-1:0]    rsi
);

	// RSI never exceeds 1.0
	a_rsi_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (rsi <= lrsi_pkg::ONE_FX))
		else $error("rsi above 1.0");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rsi))
		else $error("stalled result word changed");

	// one sample at a time: busy right after a take
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample taken while busy");

	// a result never shows the cycle right after its sample is taken
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too early");

endmodule

bind laguerre_rsi_filter_core lrsi_checker u_lrsi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.rsi       (result.rsi)
);

@@ verif/laguerre_rsi_filter_core_test.sv @@
`timescale 1ns / 1ps
module laguerre_rsi_filter_core_test;

	localparam int STAGE_WIDTH = lrsi_pkg::STAGE_WIDTH;
	localparam int FRAC_BITS   = lrsi_pkg::FRAC_BITS;
	localparam int GAMMA_W     = lrsi_pkg::GAMMA_W;
	localparam int RSI_W       = lrsi_pkg::RSI_W;
	localparam int PRICE_W     = lrsi_pkg::PRICE_W;
	localparam logic [GAMMA_W-1:0] ONE_FX      = lrsi_pkg::ONE_FX;
	localparam logic [GAMMA_W-1:0] GAMMA_RESET = lrsi_pkg::GAMMA_RESET;

	localparam longint          STG_MAX   = (64'sd1 <<< (STAGE_WIDTH - 1)) - 1;
	localparam longint          STG_MIN   = -STG_MAX - 1;
	localparam longint unsigned UNITY     = 64'd1 << FRAC_BITS;
	localparam longint unsigned FRAC_MSK  = UNITY - 1;
	localparam longint unsigned DIV_CAP   = (64'd1 << (63 - FRAC_BITS)) - 1;
	localparam logic [GAMMA_W-1:0] GAMMA_TOP = '1;
	localparam int PHASE_ITEMS     = 150;
	localparam int NUM_PHASES      = 8;
	localparam int HOLD_OFF_CYCLES = 400;

	class rsi_scoreboard;
		longint unsigned     gain;
		longint              stage[4];
		logic [RSI_W-1:0]    held;
		logic [RSI_W-1:0]    pending_rsi[$];
		int                  errors;

		function new();
			gain = GAMMA_RESET;
			stage = '{default: 0};
			held = '0;
			errors = 0;
		endfunction

		function longint clamp_stage(longint v);
			if (v > STG_MAX) return STG_MAX;
			if (v < STG_MIN) return STG_MIN;
			return v;
		endfunction

		// v * f / 2^FRAC_BITS, rounded on the magnitude, halves away from zero
		function longint scale(longint v, longint unsigned f);
			longint unsigned mag, prod;
			mag = (v < 0) ? -v : v;
			prod = (mag >> FRAC_BITS) * f + (((mag & FRAC_MSK) * f + (UNITY >> 1)) >> FRAC_BITS);
			return clamp_stage((v < 0) ? -longint'(prod) : longint'(prod));
		endfunction

		function void take_sample(logic signed [PRICE_W-1:0] price, logic first);
			longint unsigned g, up, dn, tot;
			longint prev[4];
			g = (gain > UNITY) ? UNITY : gain;
			if (first) begin
				stage = '{default: 0};
				held = '0;
			end
			prev = stage;
			stage[0] = clamp_stage(scale(longint'(price), UNITY - g) + scale(prev[0], g));
			for (int k = 1; k < 4; k++)
				stage[k] = clamp_stage(clamp_stage(prev[k-1] - scale(stage[k-1], g))
					+ scale(prev[k], g));
			// sums stay below 2^50 with 48-bit stages, no saturation needed
			up = 0;
			dn = 0;
			for (int k = 0; k < 3; k++) begin
				if (stage[k] >= stage[k+1]) up += stage[k] - stage[k+1];
				else dn += stage[k+1] - stage[k];
			end
			tot = up + dn;
			if (tot != 0) begin
				while (tot > DIV_CAP) begin
					up >>= 1;
					dn >>= 1;
					tot = up + dn;
				end
				held = RSI_W'((up * UNITY + (tot >> 1)) / tot);
			end
			pending_rsi.push_back(held);
		endfunction

		function void match_rsi(logic [RSI_W-1:0] got);
			logic [RSI_W-1:0] want;
			if (pending_rsi.size() == 0) begin
				$error("rsi: word with no sample pending, expected none, actual %0d", got);
				errors++;
			end else begin
				want = pending_rsi.pop_front();
				if (got !== want) begin
					$error("rsi mismatch: expected %0d, actual %0d", want, got);
					errors++;
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic gamma_we;
	logic [GAMMA_W-1:0] gamma_wdata;

	lrsi_sample_if sample_ch();
	lrsi_result_if result_ch();

	rsi_scoreboard sb = new();

	bit hold_off_req = 1'b0;
	bit rx_stalls = 1'b1;
	int level;
	int series_left = 0;

	laguerre_rsi_filter_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.gamma_we    (gamma_we),
		.gamma_wdata (gamma_wdata),
		.sample      (sample_ch),
		.result      (result_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_ch.valid && sample_ch.ready)
				sb.take_sample(sample_ch.close_price, sample_ch.first_in_series);
			if (result_ch.valid && result_ch.ready)
				sb.match_rsi(result_ch.rsi);
		end
	end

	// called at a falling edge; returns at the falling edge after the word is taken
	task automatic send_word(input logic signed [PRICE_W-1:0] price, input logic first);
		sample_ch.valid <= 1'b1;
		sample_ch.close_price <= price;
		sample_ch.first_in_series <= first;
		do @(posedge clk); while (!sample_ch.ready);
		@(negedge clk);
	endtask

	task automatic idle_sender(input int cycles);
		sample_ch.valid <= 1'b0;
		sample_ch.close_price <= $urandom;
		sample_ch.first_in_series <= 1'($urandom_range(0, 1));
		repeat (cycles) @(negedge clk);
	endtask

	task automatic drain();
		idle_sender(1);
		while (sb.pending_rsi.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_gamma(input logic [GAMMA_W-1:0] value);
		gamma_we <= 1'b1;
		gamma_wdata <= value;
		@(negedge clk);
		gamma_we <= 1'b0;
		gamma_wdata <= GAMMA_W'($urandom);
		sb.gain = value;
		@(negedge clk);
	endtask

	// mostly price walks inside a series, plus jumps, flat runs, extremes and stray restarts
	task automatic next_market_word(output logic signed [PRICE_W-1:0] price, output logic first);
		int pick;
		first = 1'b0;
		if (series_left == 0) begin
			first = 1'b1;
			series_left = $urandom_range(4, 60);
			level = $urandom;
		end
		series_left--;
		pick = $urandom_range(0, 99);
		if (pick < 75)
			level += (int'($urandom_range(0, 131072)) - 65536) <<< $urandom_range(0, 6);
		else if (pick < 85)
			level = $urandom;
		else if (pick < 96 && pick >= 92)
			level = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		else if (pick >= 96)
			first = 1'b1;
		price = level;
	endtask

	initial begin : receiver
		bit rdy;
		int run;
		rdy = 1'b1;
		run = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				result_ch.ready <= 1'b0;
				rdy = 1'b0;
				run = 0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
			end else if (!rx_stalls) begin
				result_ch.ready <= 1'b1;
			end else if (run == 0) begin
				rdy = !rdy;
				if (rdy) run = $urandom_range(1, 16);
				else run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
					: $urandom_range(1, 6);
				result_ch.ready <= rdy;
			end else begin
				run--;
			end
		end
	end

	initial begin : stimulus
		logic [GAMMA_W-1:0] gamma_plan[NUM_PHASES];
		logic signed [PRICE_W-1:0] price;
		logic first;
		int sent;
		int burst;
		bit calm;
		bit pressed;
		bit paused;

		arst_n = 1'b0;
		gamma_we = 1'b0;
		gamma_wdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.close_price = '0;
		sample_ch.first_in_series = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset gamma of one half, zero prices, price extremes
		send_word(0, 1'b1);
		send_word(0, 1'b0);
		send_word(32'h7FFF_FFFF, 1'b0);
		send_word(32'h8000_0000, 1'b0);
		send_word(1, 1'b0);
		send_word(-1, 1'b0);
		send_word(32'h7FFF_FFFF, 1'b1);
		drain();
		// no damping: stages become a delay line, a flat run zeroes both sums
		write_gamma('0);
		send_word(32'sd1 <<< 16, 1'b1);
		send_word(32'sd2 <<< 16, 1'b0);
		send_word(32'sd3 <<< 16, 1'b0);
		repeat (4) send_word(32'sd3 <<< 16, 1'b0);
		send_word(32'sd5 <<< 16, 1'b1);
		send_word(0, 1'b1);
		drain();
		// full damping freezes the stages
		write_gamma(ONE_FX);
		send_word(32'h1234_5678, 1'b0);
		send_word(-5, 1'b1);
		send_word(32'h7FFF_FFFF, 1'b0);
		drain();
		// register above one acts as one
		write_gamma(GAMMA_TOP);
		send_word(32'h8000_0000, 1'b0);
		send_word(32'h5555_AAAA, 1'b1);

		gamma_plan = '{GAMMA_RESET, '0, ONE_FX, 17'd1, GAMMA_TOP, ONE_FX - 17'd1,
			17'd49152, 17'd0};
		gamma_plan[7] = GAMMA_W'($urandom_range(0, 17'h1FFFF));
		gamma_plan[6] = GAMMA_W'($urandom_range(1, 17'hFFFF));
		pressed = 1'b0;
		paused = 1'b0;
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			write_gamma(gamma_plan[p]);
			calm = (p == 1 || p == 4);
			rx_stalls = !calm;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				burst = $urandom_range(1, 24);
				repeat (burst) begin
					next_market_word(price, first);
					send_word(price, first);
					sent++;
				end
				if (p == 3 && !pressed && sent >= 40) begin
					// receiver holds off; keep offering so the input backs up
					hold_off_req = 1'b1;
					repeat (8) begin
						next_market_word(price, first);
						send_word(price, first);
						sent++;
					end
					pressed = 1'b1;
				end
				if (p == 5 && !paused && sent >= 70) begin
					drain();
					paused = 1'b1;
				end else if (!calm && $urandom_range(0, 3) != 0) begin
					idle_sender($urandom_range(1, 60));
				end
			end
		end

		drain();
		repeat (60) @(posedge clk);
		if (sb.errors == 0 && sb.pending_rsi.size() == 0)
			$display("laguerre_rsi_filter_core verification clean");
		else
			$display("laguerre_rsi_filter_core verification failed");
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("laguerre_rsi_filter_core verification failed");
		$finish;
	end

endmodule

@@ laguerre_rsi_filter_core.f @@
hdl/lrsi_pkg.sv
hdl/lrsi_sample_if.sv
hdl/lrsi_result_if.sv
hdl/laguerre_rsi_filter_core.sv
hdl/lrsi_checker.sv
verif/laguerre_rsi_filter_core_test.sv
